// ===== rtl/core/cbfm_pkg.sv =====
// shared types and codes for the clock buffer frame manager
package cbfm_pkg;

    typedef enum logic [2:0] {
        OP_READ    = 3'd0,
        OP_UNPIN   = 3'd1,
        OP_ALLOC   = 3'd2,
        OP_DISPOSE = 3'd3,
        OP_FLUSH   = 3'd4
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EXCEEDED  = 3'd1,
        ST_NOT_RES   = 3'd2,
        ST_NOT_PIN   = 3'd3,
        ST_PAGE_PIN  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_SWEEP,
        S_FLUSH,
        S_OUT
    } state_t;

    localparam logic [7:0] PIN_MAX = 8'd255;

    // one result word
    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  frame_index;
        logic        fill_needed;
        logic        writeback_valid;
        logic [7:0]  writeback_file;
        logic [23:0] writeback_page;
        logic        last;
    } result_t;

endpackage

// ===== rtl/core/cbfm_table.sv =====
// frame table: one frame read and written per cycle at a sequencer-chosen index
module cbfm_table #(
    parameter int FRAMES = 16,
    parameter int IW = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [IW-1:0] idx,
    input  logic          wr_en,
    input  logic          wr_valid,
    input  logic          wr_ref,
    input  logic          wr_mod,
    input  logic [7:0]    wr_pins,
    input  logic [7:0]    wr_file,
    input  logic [23:0]   wr_page,
    output logic          rd_valid,
    output logic          rd_ref,
    output logic          rd_mod,
    output logic [7:0]    rd_pins,
    output logic [7:0]    rd_file,
    output logic [23:0]   rd_page
);
    logic [FRAMES-1:0] valid_reg;
    logic [FRAMES-1:0] ref_reg;
    logic [FRAMES-1:0] mod_reg;
    logic [7:0]  pins_reg [FRAMES];
    logic [7:0]  file_reg [FRAMES];
    logic [23:0] page_reg [FRAMES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            ref_reg   <= '0;
            mod_reg   <= '0;
        end else if (wr_en) begin
            valid_reg[idx] <= wr_valid;
            ref_reg[idx]   <= wr_ref;
            mod_reg[idx]   <= wr_mod;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            pins_reg[idx] <= wr_pins;
            file_reg[idx] <= wr_file;
            page_reg[idx] <= wr_page;
        end
    end

    // invalid frames read as cleared
    assign rd_valid = valid_reg[idx];
    assign rd_ref   = valid_reg[idx] & ref_reg[idx];
    assign rd_mod   = valid_reg[idx] & mod_reg[idx];
    assign rd_pins  = valid_reg[idx] ? pins_reg[idx] : 8'd0;
    assign rd_file  = valid_reg[idx] ? file_reg[idx] : 8'd0;
    assign rd_page  = valid_reg[idx] ? page_reg[idx] : 24'd0;
endmodule

// ===== rtl/core/clock_buffer_frame_manager.sv =====
// top level of the clock buffer frame manager
// Use: one operation word enters on s_ (opcode, file_id, page_number, set_dirty)
// and gives one or more result words on m_; the final one has m_last set.
// A sequencer walks a single frame table port, one frame per cycle.
// Lookup (read-pin, unpin, allocate, dispose) scans frames 0..FRAMES-1 and
// stops at the first tag match. A read or allocate miss then runs the clock
// sweep, one frame per cycle, over at most 2*FRAMES frames. Flush walks the
// frames one per cycle while no result waits; a pinned frame of the file ends it.
// Result words wait in an output register until m_ready; s_ready is high only
// when the block is idle with no pending result.
// Reset (aresetn low, synchronous) clears all frames and sets the hand to the
// last frame; the block is ready as soon as reset is released.
// A stalled receiver holds the result register and the sequencer waits.
module clock_buffer_frame_manager #(
    parameter int FRAMES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_opcode,
    input  logic [7:0]  s_file_id,
    input  logic [23:0] s_page_number,
    input  logic        s_set_dirty,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [3:0]  m_frame_index,
    output logic        m_fill_needed,
    output logic        m_writeback_valid,
    output logic [7:0]  m_writeback_file,
    output logic [23:0] m_writeback_page,
    output logic        m_last
);
    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW = IW + 2;
    localparam logic [IW-1:0] LAST_IDX = IW'(FRAMES - 1);

    cbfm_pkg::state_t state_reg, state_next;
    logic [2:0]  op_reg;
    logic [7:0]  file_reg;
    logic [23:0] page_reg;
    logic        dirty_reg;
    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] hand_reg, hand_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic        after_reg, after_next; // flush: return to walk after the word
    cbfm_pkg::result_t res_reg, res_next;
    logic        out_v_reg, out_v_next;

    logic          wr_en, wr_valid, wr_ref, wr_mod;
    logic [7:0]    wr_pins, wr_file;
    logic [23:0]   wr_page;
    logic          rd_valid, rd_ref, rd_mod;
    logic [7:0]    rd_pins, rd_file;
    logic [23:0]   rd_page;
    logic [IW-1:0] tidx;
    logic          match;
    logic [IW-1:0] hand_inc;
    logic          out_busy;

    cbfm_table #(.FRAMES(FRAMES), .IW(IW)) u_table (
        .aclk, .aresetn, .idx(tidx), .wr_en, .wr_valid, .wr_ref, .wr_mod,
        .wr_pins, .wr_file, .wr_page, .rd_valid, .rd_ref, .rd_mod,
        .rd_pins, .rd_file, .rd_page
    );

    assign hand_inc = (hand_reg == LAST_IDX) ? '0 : hand_reg + 1'b1;
    assign tidx = (state_reg == cbfm_pkg::S_SWEEP) ? hand_inc : idx_reg;
    assign match = rd_valid && rd_file == file_reg && rd_page == page_reg;
    assign s_ready = (state_reg == cbfm_pkg::S_IDLE) && !out_v_reg;
    // previous word still waiting for the receiver
    assign out_busy = out_v_reg && !m_ready;

    function automatic cbfm_pkg::result_t mk(input logic [2:0] st,
                                             input logic [IW-1:0] fr,
                                             input logic lst);
        cbfm_pkg::result_t r;
        r = '0;
        r.status = st;
        r.frame_index = 4'(fr);
        r.last = lst;
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cbfm_pkg::S_IDLE;
            hand_reg  <= LAST_IDX;
            out_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            hand_reg  <= hand_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg    <= s_opcode;
            file_reg  <= s_file_id;
            page_reg  <= s_page_number;
            dirty_reg <= s_set_dirty;
        end
        idx_reg   <= idx_next;
        cnt_reg   <= cnt_next;
        after_reg <= after_next;
        res_reg   <= res_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cbfm_pkg::S_IDLE: begin
                if (s_valid && s_ready) begin
                    if (s_opcode == cbfm_pkg::OP_FLUSH) state_next = cbfm_pkg::S_FLUSH;
                    else if (s_opcode inside {cbfm_pkg::OP_READ, cbfm_pkg::OP_UNPIN,
                                              cbfm_pkg::OP_ALLOC, cbfm_pkg::OP_DISPOSE})
                        state_next = cbfm_pkg::S_LOOK;
                    else state_next = cbfm_pkg::S_OUT;
                end
            end
            cbfm_pkg::S_LOOK: begin
                if (match) state_next = cbfm_pkg::S_OUT;
                else if (idx_reg == LAST_IDX) begin
                    if (op_reg == cbfm_pkg::OP_READ || op_reg == cbfm_pkg::OP_ALLOC)
                        state_next = cbfm_pkg::S_SWEEP;
                    else state_next = cbfm_pkg::S_OUT;
                end
            end
            cbfm_pkg::S_SWEEP: begin
                if (!rd_valid || (!rd_ref && rd_pins == 8'd0)
                    || cnt_reg == CW'(2 * FRAMES - 1))
                    state_next = cbfm_pkg::S_OUT;
            end
            cbfm_pkg::S_FLUSH: begin
                if (!out_busy) begin
                    if (rd_valid && rd_file == file_reg
                        && (rd_pins != 8'd0 || rd_mod || idx_reg == LAST_IDX))
                        state_next = cbfm_pkg::S_OUT;
                    else if (idx_reg == LAST_IDX) state_next = cbfm_pkg::S_OUT;
                end
            end
            cbfm_pkg::S_OUT: begin
                if (!out_v_reg || m_ready)
                    state_next = after_reg ? cbfm_pkg::S_FLUSH : cbfm_pkg::S_IDLE;
            end
            default: state_next = cbfm_pkg::S_IDLE;
        endcase
    end

    // datapath and table writes
    always_comb begin
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        after_next = after_reg;
        hand_next  = hand_reg;
        res_next   = res_reg;
        out_v_next = out_v_reg && !m_ready;
        wr_en    = 1'b0;
        wr_valid = rd_valid;
        wr_ref   = rd_ref;
        wr_mod   = rd_mod;
        wr_pins  = rd_pins;
        wr_file  = rd_file;
        wr_page  = rd_page;
        case (state_reg)
            cbfm_pkg::S_IDLE: begin
                idx_next   = '0;
                cnt_next   = '0;
                after_next = 1'b0;
                if (s_valid && s_ready) res_next = mk(cbfm_pkg::ST_OK, '0, 1'b1);
            end
            cbfm_pkg::S_LOOK: begin
                if (match) begin
                    res_next = mk(cbfm_pkg::ST_OK, idx_reg, 1'b1);
                    case (op_reg)
                        cbfm_pkg::OP_UNPIN: begin
                            if (rd_pins == 8'd0) begin
                                res_next.status = cbfm_pkg::ST_NOT_PIN;
                            end else begin
                                wr_en   = 1'b1;
                                wr_pins = rd_pins - 8'd1;
                                wr_mod  = rd_mod | dirty_reg;
                            end
                        end
                        cbfm_pkg::OP_DISPOSE: begin
                            wr_en = 1'b1;
                            wr_valid = 1'b0; wr_ref = 1'b0; wr_mod = 1'b0;
                            wr_pins = '0; wr_file = '0; wr_page = '0;
                        end
                        default: begin
                            wr_en  = 1'b1;
                            wr_ref = 1'b1;
                            if (rd_pins != cbfm_pkg::PIN_MAX) wr_pins = rd_pins + 8'd1;
                        end
                    endcase
                end else if (idx_reg == LAST_IDX) begin
                    res_next = mk(cbfm_pkg::ST_OK, '0, 1'b1);
                    if (op_reg == cbfm_pkg::OP_UNPIN) res_next.status = cbfm_pkg::ST_NOT_RES;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            cbfm_pkg::S_SWEEP: begin
                hand_next = hand_inc;
                cnt_next  = cnt_reg + 1'b1;
                if (!rd_valid || (!rd_ref && rd_pins == 8'd0)) begin
                    res_next = mk(cbfm_pkg::ST_OK, hand_inc, 1'b1);
                    res_next.fill_needed = (op_reg == cbfm_pkg::OP_READ);
                    res_next.writeback_valid = rd_mod;
                    res_next.writeback_file  = rd_mod ? rd_file : 8'd0;
                    res_next.writeback_page  = rd_mod ? rd_page : 24'd0;
                    wr_en = 1'b1;
                    wr_valid = 1'b1; wr_ref = 1'b1; wr_mod = 1'b0;
                    wr_pins = 8'd1; wr_file = file_reg; wr_page = page_reg;
                end else begin
                    if (rd_ref) begin
                        wr_en  = 1'b1;
                        wr_ref = 1'b0;
                    end
                    if (cnt_reg == CW'(2 * FRAMES - 1))
                        res_next = mk(cbfm_pkg::ST_EXCEEDED, '0, 1'b1);
                end
            end
            cbfm_pkg::S_FLUSH: begin
                if (!out_busy) begin
                    after_next = 1'b0;
                    res_next   = mk(cbfm_pkg::ST_OK, '0, 1'b1);
                    if (rd_valid && rd_file == file_reg) begin
                        if (rd_pins != 8'd0) begin
                            res_next = mk(cbfm_pkg::ST_PAGE_PIN, idx_reg, 1'b1);
                        end else begin
                            wr_en = 1'b1;
                            wr_valid = 1'b0; wr_ref = 1'b0; wr_mod = 1'b0;
                            wr_pins = '0; wr_file = '0; wr_page = '0;
                            if (rd_mod) begin
                                res_next = mk(cbfm_pkg::ST_OK, idx_reg, 1'b0);
                                res_next.writeback_valid = 1'b1;
                                res_next.writeback_file  = rd_file;
                                res_next.writeback_page  = rd_page;
                                // on the last frame the revisit finds it cleared
                                // and gives the closing word
                                after_next = 1'b1;
                            end
                        end
                    end
                    if (idx_reg != LAST_IDX) idx_next = idx_reg + 1'b1;
                end
            end
            cbfm_pkg::S_OUT: begin
                if (!out_v_reg || m_ready) out_v_next = 1'b1;
            end
            default: ;
        endcase
    end

    assign m_valid           = out_v_reg;
    assign m_status          = res_reg.status;
    assign m_frame_index     = res_reg.frame_index;
    assign m_fill_needed     = res_reg.fill_needed;
    assign m_writeback_valid = res_reg.writeback_valid;
    assign m_writeback_file  = res_reg.writeback_file;
    assign m_writeback_page  = res_reg.writeback_page;
    assign m_last            = res_reg.last;
endmodule

// ===== rtl/core/cbfm_checker.sv =====
// port checker for the clock buffer frame manager
module cbfm_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_last,
    input logic [2:0] m_status,
    input logic       m_fill_needed,
    input logic       m_writeback_valid
);
    // no new word taken while a result waits
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("s_ready while result pending");
    // a held result stays
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status))
        else $error("result dropped");
    // not-last words are write-backs
    a_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> m_writeback_valid) else $error("bad mid word");
    // fill only on a grant
    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_fill_needed |-> m_status == cbfm_pkg::ST_OK) else $error("bad fill");
endmodule

bind clock_buffer_frame_manager cbfm_checker u_cbfm_checker (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .m_last,
    .m_status, .m_fill_needed, .m_writeback_valid
);
